/* src/strk_pkg.sv */
// ----------------------------------------------------------------------------
// strk_pkg
// Shared types and constants for the score table with rank and ordered readout.
// ----------------------------------------------------------------------------
`default_nettype none

package strk_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int ID_W        = 5;
  localparam int CNT_W       = 6;
  localparam int TOTAL_W     = 16;
  localparam int PTS_W       = 8;

  localparam logic KIND_SCORE   = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  // one read and one write access to the score table per cycle
  typedef struct packed {
    logic [ID_W-1:0]           rd_addr;
    logic                      wr_en;
    logic [ID_W-1:0]           wr_addr;
    logic signed [TOTAL_W-1:0] wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

/* src/score_table_rank_and_order.sv */
// ----------------------------------------------------------------------------
// score_table_rank_and_order
// Score table with saturating updates, rank report and ordered readout.
// ----------------------------------------------------------------------------
// One request at a time goes through a sequencer around a single-port-read
// score memory, n being the entry count in use (capped at 32). A score request
// reads the entry, writes the saturated total, then makes one memory read per
// entry to count higher totals. A readout request runs a selection pass per
// reported entry, each pass reading all n entries; the table gives one read
// per cycle. A bad entry id is answered without a table scan, a readout with
// a count of zero gives no results. A stalled result output holds the sequencer
// in its emit state. The table comes out of reset ready, with no clearing pass.
`default_nettype none

module score_table_rank_and_order
  import strk_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CNT_W-1:0]          cfg_entry_count,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_kind,
  input  wire logic [ID_W-1:0]           in_entry_id,
  input  wire logic signed [PTS_W-1:0]   in_points,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ID_W-1:0]                out_entry,
  output logic signed [TOTAL_W-1:0]      out_total,
  output logic [CNT_W-1:0]               out_rank,
  output logic                           out_error,
  output logic                           out_last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_UPD   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cfg_count_r;
  logic [CNT_W-1:0]          n_eff;

  logic                      kind_r, kind_nxt;
  logic                      err_r, err_nxt;
  logic [ID_W-1:0]           id_r, id_nxt;
  logic signed [PTS_W-1:0]   pts_r, pts_nxt;
  logic signed [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]          rank_r, rank_nxt;
  logic [ID_W-1:0]           scan_idx_r, scan_idx_nxt;
  logic                      pend_r, pend_nxt;
  logic [ID_W-1:0]           pend_idx_r, pend_idx_nxt;
  logic [MAX_ENTRIES-1:0]    taken_r, taken_nxt;
  logic                      found_r, found_nxt;
  logic [ID_W-1:0]           best_idx_r, best_idx_nxt;
  logic signed [TOTAL_W-1:0] best_total_r, best_total_nxt;
  logic [ID_W-1:0]           pos_r, pos_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]           out_entry_r, out_entry_nxt;
  logic signed [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [CNT_W-1:0]          out_rank_r, out_rank_nxt;
  logic                      out_error_r, out_error_nxt;
  logic                      out_last_r, out_last_nxt;

  tbl_req_t                  tbl_req;
  logic signed [TOTAL_W-1:0] tbl_rd;
  logic signed [TOTAL_W:0]   sum_wide;
  logic signed [TOTAL_W-1:0] sum_sat;
  logic                      out_free;
  logic [CNT_W-1:0]          pos_next_rank;

  strk_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  assign n_eff = (cfg_count_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cfg_count_r;

  assign sum_wide = {tbl_rd[TOTAL_W-1], tbl_rd}
                  + {{(TOTAL_W + 1 - PTS_W){pts_r[PTS_W-1]}}, pts_r};

  always_comb begin
    if (sum_wide > $signed({2'b00, {(TOTAL_W-1){1'b1}}})) begin
      sum_sat = {1'b0, {(TOTAL_W-1){1'b1}}};
    end else if (sum_wide < $signed({2'b11, {(TOTAL_W-1){1'b0}}})) begin
      sum_sat = {1'b1, {(TOTAL_W-1){1'b0}}};
    end else begin
      sum_sat = sum_wide[TOTAL_W-1:0];
    end
  end

  // the write happens in its own state and scan reads start in the state after it,
  // so no scan read meets a write to the same entry
  always_comb begin
    tbl_req.rd_addr = (state_r == ST_IDLE) ? in_entry_id : scan_idx_r;
    tbl_req.wr_en   = (state_r == ST_UPD);
    tbl_req.wr_addr = id_r;
    tbl_req.wr_data = sum_sat;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_ready;
  assign pos_next_rank = {1'b0, pos_r} + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    err_nxt        = err_r;
    id_nxt         = id_r;
    pts_nxt        = pts_r;
    sum_nxt        = sum_r;
    rank_nxt       = rank_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    taken_nxt      = taken_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_total_nxt = best_total_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_entry_nxt  = out_entry_r;
    out_total_nxt  = out_total_r;
    out_rank_nxt   = out_rank_r;
    out_error_nxt  = out_error_r;
    out_last_nxt   = out_last_r;

    // compare stage for the entry whose registered read data is now on tbl_rd
    if (pend_r) begin
      if (kind_r == KIND_SCORE) begin
        if (pend_idx_r != id_r && tbl_rd > sum_r) begin
          rank_nxt = rank_r + CNT_W'(1);
        end
      end else if (!taken_r[pend_idx_r] && (!found_r || tbl_rd > best_total_r)) begin
        best_idx_nxt   = pend_idx_r;
        best_total_nxt = tbl_rd;
        found_nxt      = 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          id_nxt   = in_entry_id;
          pts_nxt  = in_points;
          err_nxt  = 1'b0;
          if (in_kind == KIND_SCORE) begin
            if ({1'b0, in_entry_id} >= n_eff) begin
              err_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_UPD;
            end
          end else if (n_eff != '0) begin
            taken_nxt    = '0;
            pos_nxt      = '0;
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_UPD: begin
        sum_nxt      = sum_sat;
        rank_nxt     = CNT_W'(1);
        scan_idx_nxt = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = scan_idx_r;
        if ({1'b0, scan_idx_r} == n_eff - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + ID_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_SCORE) begin
            out_entry_nxt = id_r;
            out_total_nxt = err_r ? '0 : sum_r;
            out_rank_nxt  = err_r ? '0 : rank_r;
            out_error_nxt = err_r;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            out_entry_nxt        = best_idx_r;
            out_total_nxt        = best_total_r;
            out_rank_nxt         = pos_next_rank;
            out_error_nxt        = 1'b0;
            out_last_nxt         = (pos_next_rank == n_eff);
            taken_nxt[best_idx_r] = 1'b1;
            if (pos_next_rank == n_eff) begin
              state_nxt = ST_IDLE;
            end else begin
              pos_nxt      = pos_r + ID_W'(1);
              scan_idx_nxt = '0;
              found_nxt    = 1'b0;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_count_r <= CNT_W'(MAX_ENTRIES);
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_entry_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    err_r        <= err_nxt;
    id_r         <= id_nxt;
    pts_r        <= pts_nxt;
    sum_r        <= sum_nxt;
    rank_r       <= rank_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    taken_r      <= taken_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_total_r <= best_total_nxt;
    pos_r        <= pos_nxt;
    out_entry_r  <= out_entry_nxt;
    out_total_r  <= out_total_nxt;
    out_rank_r   <= out_rank_nxt;
    out_error_r  <= out_error_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_entry = out_entry_r;
  assign out_total = out_total_r;
  assign out_rank  = out_rank_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |-> out_last_r && out_rank_r == '0 && out_total_r == '0)
    else $error("error result not final or not cleared");

  a_good_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_error_r |-> out_rank_r != '0)
    else $error("good result with zero rank");

  a_pend_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == ST_SCAN))
    else $error("compare stage without a scan read");

  a_best_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && kind_r == KIND_READOUT |-> found_r && !taken_r[best_idx_r])
    else $error("readout picked an entry already reported");
`endif

endmodule

`default_nettype wire

/* src/strk_table.sv */
// ----------------------------------------------------------------------------
// strk_table
// Score total memory, one write and one registered read per cycle. Entries
// never written since reset read back as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module strk_table
  import strk_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tbl_req_t                  req,
  output logic signed [TOTAL_W-1:0]      rd_data
);

  logic signed [TOTAL_W-1:0] mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    vld_r;
  logic signed [TOTAL_W-1:0] rd_data_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* tb/score_table_rank_and_order_checker.sv */
// ----------------------------------------------------------------------------
// score_table_rank_and_order_checker
// Watches the request, result and entry count ports of the score table, keeps
// its own copy of the totals, predicts every result and compares in order.
// ----------------------------------------------------------------------------

module score_table_rank_and_order_checker
  import strk_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_entry_count,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_kind,
  input  logic [ID_W-1:0]           in_entry_id,
  input  logic signed [PTS_W-1:0]   in_points,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [ID_W-1:0]           out_entry,
  input  logic signed [TOTAL_W-1:0] out_total,
  input  logic [CNT_W-1:0]          out_rank,
  input  logic                      out_error,
  input  logic                      out_last,
  output int                        failures,
  output int                        pending,
  output int                        results_seen
);

  typedef struct packed {
    logic [ID_W-1:0]           entry;
    logic signed [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]          place;
    logic                      err;
    logic                      last;
  } standing_t;

  standing_t                 standings_q[$];
  logic signed [TOTAL_W-1:0] totals_mem [MAX_ENTRIES];
  logic [CNT_W-1:0]          count_reg;

  function automatic int live_count();
    int c;
    c = int'(count_reg);
    if (c > MAX_ENTRIES) c = MAX_ENTRIES;
    return c;
  endfunction

  // works out the results of one request and, for a score request, updates the totals
  task automatic predict_standings(input logic kind, input logic [ID_W-1:0] id,
                                   input logic signed [PTS_W-1:0] pts);
    int n, sum, place, pos, i, best;
    logic [MAX_ENTRIES-1:0] taken;
    bit found;
    standing_t s;
    n = live_count();
    if (kind == KIND_SCORE) begin
      s.entry = id;
      s.last  = 1'b1;
      if (int'(id) >= n) begin
        s.total = '0;
        s.place = '0;
        s.err   = 1'b1;
      end else begin
        sum = int'(totals_mem[id]) + int'(pts);
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        totals_mem[id] = sum[TOTAL_W-1:0];
        place = 1;
        for (i = 0; i < n; i++)
          if (i != int'(id) && totals_mem[i] > totals_mem[id]) place++;
        s.total = totals_mem[id];
        s.place = CNT_W'(place);
        s.err   = 1'b0;
      end
      standings_q.push_back(s);
    end else begin
      taken = '0;
      for (pos = 0; pos < n; pos++) begin
        best  = 0;
        found = 0;
        for (i = 0; i < n; i++) begin
          if (!taken[i] && (!found || totals_mem[i] > totals_mem[best])) begin
            best  = i;
            found = 1;
          end
        end
        taken[best] = 1'b1;
        s.entry = ID_W'(best);
        s.total = totals_mem[best];
        s.place = CNT_W'(pos + 1);
        s.err   = 1'b0;
        s.last  = (pos == n - 1);
        standings_q.push_back(s);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    standing_t got, want;
    int i;
    if (!rst_n) begin
      count_reg = CNT_W'(MAX_ENTRIES);
      for (i = 0; i < MAX_ENTRIES; i++) totals_mem[i] = '0;
      standings_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.entry = out_entry;
        got.total = out_total;
        got.place = out_rank;
        got.err   = out_error;
        got.last  = out_last;
        results_seen++;
        if (standings_q.size() == 0) begin
          failures++;
          $display("%0t unexpected result: entry %0d total %0d rank %0d error %0b last %0b",
                   $time, got.entry, got.total, got.place, got.err, got.last);
        end else begin
          want = standings_q.pop_front();
          if (got.entry !== want.entry || got.total !== want.total ||
              got.place !== want.place || got.err !== want.err || got.last !== want.last)
          begin
            failures++;
            $display("%0t result mismatch: expected entry %0d total %0d rank %0d error %0b last %0b",
                     $time, want.entry, want.total, want.place, want.err, want.last);
            $display("%0t                  actual   entry %0d total %0d rank %0d error %0b last %0b",
                     $time, got.entry, got.total, got.place, got.err, got.last);
          end
        end
      end
      if (cfg_wr_en) count_reg = cfg_entry_count;
      if (in_valid && in_ready) predict_standings(in_kind, in_entry_id, in_points);
    end
    pending = standings_q.size();
  end

endmodule

/* tb/score_table_rank_and_order_test.sv */
// ----------------------------------------------------------------------------
// score_table_rank_and_order_test
// Drives score and readout requests into the score table across a range of
// entry counts, with bursty requests and a stalling result side; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module score_table_rank_and_order_test
  import strk_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int SAT_STEPS      = 270;
  localparam int MIX_PHASES     = 8;
  localparam int MIX_ITEMS      = 16;

  localparam logic signed [PTS_W-1:0] PTS_MAX = PTS_W'(127);
  localparam logic signed [PTS_W-1:0] PTS_MIN = PTS_W'(-128);

  typedef enum int {RX_OPEN, RX_COIN, RX_BLIP, RX_SLOW} rx_mode_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CNT_W-1:0]          cfg_entry_count;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_kind;
  logic [ID_W-1:0]           in_entry_id;
  logic signed [PTS_W-1:0]   in_points;
  logic                      out_valid;
  logic                      out_ready;
  logic [ID_W-1:0]           out_entry;
  logic signed [TOTAL_W-1:0] out_total;
  logic [CNT_W-1:0]          out_rank;
  logic                      out_error;
  logic                      out_last;

  int failures, pending, results_seen;
  int requests_sent, count_writes;
  int hold_asks, hold_done;
  int burst_left, gap_max, active_n;
  int phase, k, pick, climbs, readout_odds, next_count, quiet, tick, mode_len;
  logic [ID_W-1:0]         id;
  logic signed [PTS_W-1:0] pts;
  rx_mode_t                ready_mode;

  score_table_rank_and_order DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_entry_count (cfg_entry_count),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_entry_id     (in_entry_id),
    .in_points       (in_points),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry       (out_entry),
    .out_total       (out_total),
    .out_rank        (out_rank),
    .out_error       (out_error),
    .out_last        (out_last)
  );

  score_table_rank_and_order_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_entry_count (cfg_entry_count),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_entry_id     (in_entry_id),
    .in_points       (in_points),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry       (out_entry),
    .out_total       (out_total),
    .out_rank        (out_rank),
    .out_error       (out_error),
    .out_last        (out_last),
    .failures        (failures),
    .pending         (pending),
    .results_seen    (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request per call; valid stays high from one request to the next within a burst
  task automatic send_request(input logic kind, input logic [ID_W-1:0] rid,
                              input logic signed [PTS_W-1:0] rpts);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_entry_id <= rid;
    in_points   <= rpts;
    do @(posedge clk); while (in_ready !== 1'b1);
    requests_sent++;
  endtask

  // wait until every expected result is back and the block has gone quiet
  task automatic finish_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input int value);
    @(negedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_entry_count <= CNT_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    active_n = (value > MAX_ENTRIES) ? MAX_ENTRIES : value;
    count_writes++;
  endtask

  // result side: changing stall patterns, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      ready_mode = rx_mode_t'($urandom_range(0, 3));
      mode_len   = $urandom_range(30, 250);
      repeat (mode_len) begin
        @(negedge clk);
        tick++;
        if (hold_asks != hold_done) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_done++;
        end else begin
          case (ready_mode)
            RX_OPEN: out_ready <= 1'b1;
            RX_COIN: out_ready <= 1'($urandom_range(0, 1));
            RX_BLIP: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= (tick % 4 == 0);
          endcase
        end
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("score_table_rank_and_order regression: fail");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_entry_count = '0;
    in_valid        = 1'b0;
    in_kind         = KIND_SCORE;
    in_entry_id     = '0;
    in_points       = '0;
    burst_left      = 0;
    gap_max         = 6;
    active_n        = MAX_ENTRIES;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-zero table: every position is a tie
    send_request(KIND_READOUT, '0, '0);
    send_request(KIND_SCORE, ID_W'(0), PTS_MAX);
    send_request(KIND_SCORE, ID_W'(31), PTS_MIN);
    send_request(KIND_SCORE, ID_W'(5), PTS_MAX);
    send_request(KIND_SCORE, ID_W'(5), PTS_W'(0));
    send_request(KIND_SCORE, ID_W'(17), PTS_W'(-1));
    send_request(KIND_SCORE, ID_W'(3), PTS_W'(1));
    send_request(KIND_SCORE, ID_W'(3), PTS_MIN);
    send_request(KIND_READOUT, '1, '1);

    // zero count: only errors, and a readout with nothing to report
    finish_phase();
    write_count(0);
    send_request(KIND_SCORE, ID_W'(0), PTS_W'(5));
    send_request(KIND_READOUT, '0, '0);
    send_request(KIND_SCORE, ID_W'(31), PTS_MIN);

    // oversized count acts as a full table
    finish_phase();
    write_count(63);
    send_request(KIND_SCORE, ID_W'(31), PTS_MAX);
    send_request(KIND_READOUT, '0, '0);

    // single entry; entries outside the count keep their totals
    finish_phase();
    write_count(1);
    send_request(KIND_SCORE, ID_W'(0), PTS_MIN);
    send_request(KIND_SCORE, ID_W'(1), PTS_MAX);
    send_request(KIND_READOUT, '0, '0);

    finish_phase();
    write_count(33);
    send_request(KIND_SCORE, ID_W'(31), PTS_W'(-1));
    send_request(KIND_SCORE, ID_W'(16), PTS_MIN);

    // one entry pushed past the upper limit, with some noise mixed in
    finish_phase();
    write_count(2);
    gap_max = 8;
    hold_asks++;
    climbs = 0;
    while (climbs < SAT_STEPS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_request(KIND_READOUT, ID_W'($urandom), PTS_W'($urandom));
      end else if (pick == 1) begin
        send_request(KIND_SCORE, ID_W'($urandom), PTS_W'($urandom));
      end else begin
        send_request(KIND_SCORE, ID_W'(0), PTS_MAX);
        climbs++;
      end
    end

    for (phase = 0; phase < MIX_PHASES; phase++) begin
      finish_phase();
      pick = $urandom_range(0, 9);
      if (pick < 5)       next_count = $urandom_range(2, 8);
      else if (pick < 7)  next_count = $urandom_range(9, 16);
      else if (pick == 7) next_count = $urandom_range(0, 1);
      else if (pick == 8) next_count = $urandom_range(33, 63);
      else                next_count = MAX_ENTRIES;
      write_count(next_count);
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 25);
      if (phase == 4) hold_asks++;
      for (k = 0; k < MIX_ITEMS; k++) begin
        // full-size readouts are slow, keep them rare
        readout_odds = (active_n > 16) ? 20 : 6;
        if ($urandom_range(1, readout_odds) == 1) begin
          send_request(KIND_READOUT, ID_W'($urandom), PTS_W'($urandom));
        end else begin
          if ($urandom_range(0, 4) != 0)
            id = ID_W'($urandom_range(0, (active_n == 0) ? 0 : active_n - 1));
          else
            id = ID_W'($urandom);
          if ($urandom_range(0, 7) == 0) pts = $urandom_range(0, 1) ? PTS_MAX : PTS_MIN;
          else pts = PTS_W'($urandom);
          send_request(KIND_SCORE, id, pts);
        end
      end
    end

    // back to the reset count: full ordering with a saturated top entry
    finish_phase();
    write_count(MAX_ENTRIES);
    send_request(KIND_READOUT, '0, '0);
    send_request(KIND_SCORE, ID_W'(0), PTS_MAX);
    send_request(KIND_SCORE, ID_W'(1), PTS_MIN);
    finish_phase();

    $display("run summary: %0d requests, %0d results checked, %0d entry count writes",
             requests_sent, results_seen, count_writes);
    $display("covered zero, small, full and oversized counts, bad ids, upper score limit");
    if (failures == 0)
      $display("score_table_rank_and_order regression: pass");
    else
      $display("score_table_rank_and_order regression: fail");
    $finish;
  end

endmodule
